@@ src/salsa20_8_core_permutation_defines.svh @@
// ----------------------------------------------------------------------------
// Salsa20/8 core assertion macros
// Shared concurrent assertion forms for the permutation core.
// ----------------------------------------------------------------------------
`ifndef SALSA20_8_CORE_PERMUTATION_DEFINES_SVH
`define SALSA20_8_CORE_PERMUTATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SALSA8_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("salsa8 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SALSA8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("salsa8 assertion failed");

`endif

@@ src/salsa8_pkg.sv @@
// ----------------------------------------------------------------------------
// Salsa20/8 core package
// Types, round tables and pipeline constants shared by the core modules.
// ----------------------------------------------------------------------------
package salsa8_pkg;

    localparam int ROUNDS  = 8;
    localparam int NLANES  = 4;
    localparam int NSTEPS  = 4;
    localparam int STAGES  = NSTEPS * ROUNDS;
    localparam int LATENCY = STAGES + 1;

    typedef logic [31:0]       t_word;
    typedef t_word [15:0]      t_words;
    typedef logic [3:0]        t_idx;
    typedef logic [1:0]        t_role;
    typedef logic [4:0]        t_rot;

    typedef struct packed {
        logic        row;
        logic [1:0]  step;
    } t_stage_ctl;

    typedef struct packed {
        logic [63:0] in_words_14_15;
        logic [63:0] in_words_12_13;
        logic [63:0] in_words_10_11;
        logic [63:0] in_words_8_9;
        logic [63:0] in_words_6_7;
        logic [63:0] in_words_4_5;
        logic [63:0] in_words_2_3;
        logic [63:0] in_words_0_1;
    } t_in;

    typedef struct packed {
        logic [63:0] out_words_14_15;
        logic [63:0] out_words_12_13;
        logic [63:0] out_words_10_11;
        logic [63:0] out_words_8_9;
        logic [63:0] out_words_6_7;
        logic [63:0] out_words_4_5;
        logic [63:0] out_words_2_3;
        logic [63:0] out_words_0_1;
    } t_out;

    // Word indexes (a, b, c, d) of each lane: column round, then row round.
    localparam t_idx QR_IDX [2][NLANES][4] = '{
        '{ '{4'd0,  4'd4,  4'd8,  4'd12},
           '{4'd5,  4'd9,  4'd13, 4'd1 },
           '{4'd10, 4'd14, 4'd2,  4'd6 },
           '{4'd15, 4'd3,  4'd7,  4'd11} },
        '{ '{4'd0,  4'd1,  4'd2,  4'd3 },
           '{4'd5,  4'd6,  4'd7,  4'd4 },
           '{4'd10, 4'd11, 4'd8,  4'd9 },
           '{4'd15, 4'd12, 4'd13, 4'd14} }
    };

    // Per step: updated word role, the two addend roles and the rotation.
    localparam t_role TGT_ROLE [NSTEPS] = '{2'd1, 2'd2, 2'd3, 2'd0};
    localparam t_role YA_ROLE  [NSTEPS] = '{2'd0, 2'd1, 2'd2, 2'd3};
    localparam t_role ZB_ROLE  [NSTEPS] = '{2'd3, 2'd0, 2'd1, 2'd2};
    localparam t_rot  ROT      [NSTEPS] = '{5'd7, 5'd9, 5'd13, 5'd18};

endpackage

@@ src/salsa8_lane.sv @@
// ----------------------------------------------------------------------------
// Salsa20/8 lane
// One add, rotate-left and xor step of a quarter round.
// ----------------------------------------------------------------------------
module salsa8_lane (
    input  salsa8_pkg::t_word i_x,
    input  salsa8_pkg::t_word i_y,
    input  salsa8_pkg::t_word i_z,
    input  salsa8_pkg::t_rot  i_rot,
    output salsa8_pkg::t_word o_x
);

    salsa8_pkg::t_word w_sum;
    logic [63:0]       w_dbl;

    assign w_sum = i_y + i_z;
    assign w_dbl = {w_sum, w_sum} << i_rot;
    assign o_x   = i_x ^ w_dbl[63:32];

endmodule

@@ src/salsa8_stage.sv @@
// ----------------------------------------------------------------------------
// Salsa20/8 round stage
// Four lanes run one quarter-round step in parallel; the state is registered.
// ----------------------------------------------------------------------------
module salsa8_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  salsa8_pkg::t_stage_ctl i_ctl,
    input  logic                   i_valid,
    input  salsa8_pkg::t_words     i_words,
    input  salsa8_pkg::t_words     i_orig,
    output logic                   o_valid,
    output salsa8_pkg::t_words     o_words,
    output salsa8_pkg::t_words     o_orig
);

    salsa8_pkg::t_idx   w_tgt [salsa8_pkg::NLANES];
    salsa8_pkg::t_idx   w_ya  [salsa8_pkg::NLANES];
    salsa8_pkg::t_idx   w_zb  [salsa8_pkg::NLANES];
    salsa8_pkg::t_word  w_lane[salsa8_pkg::NLANES];
    salsa8_pkg::t_rot   w_rot;

    logic               r_valid;
    salsa8_pkg::t_words r_words;
    salsa8_pkg::t_words r_orig;
    salsa8_pkg::t_words n_words;

    assign w_rot = salsa8_pkg::ROT[i_ctl.step];

    always_comb begin
        for (int l = 0; l < salsa8_pkg::NLANES; l++) begin
            w_tgt[l] = salsa8_pkg::QR_IDX[i_ctl.row][l][salsa8_pkg::TGT_ROLE[i_ctl.step]];
            w_ya[l]  = salsa8_pkg::QR_IDX[i_ctl.row][l][salsa8_pkg::YA_ROLE[i_ctl.step]];
            w_zb[l]  = salsa8_pkg::QR_IDX[i_ctl.row][l][salsa8_pkg::ZB_ROLE[i_ctl.step]];
        end
    end

    for (genvar l = 0; l < salsa8_pkg::NLANES; l++) begin : g_lane
        salsa8_lane u_lane (
            .i_x   (i_words[w_tgt[l]]),
            .i_y   (i_words[w_ya[l]]),
            .i_z   (i_words[w_zb[l]]),
            .i_rot (w_rot),
            .o_x   (w_lane[l])
        );
    end

    always_comb begin
        n_words = i_words;
        for (int l = 0; l < salsa8_pkg::NLANES; l++) begin
            n_words[w_tgt[l]] = w_lane[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
        r_orig  <= i_orig;
    end

    assign o_valid = r_valid;
    assign o_words = r_words;
    assign o_orig  = r_orig;

endmodule

@@ src/salsa8_merge.sv @@
// ----------------------------------------------------------------------------
// Salsa20/8 merge stage
// Adds the original words back and packs the result transaction.
// ----------------------------------------------------------------------------
module salsa8_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  salsa8_pkg::t_words i_words,
    input  salsa8_pkg::t_words i_orig,
    output logic               o_valid,
    output salsa8_pkg::t_out   o_result
);

    salsa8_pkg::t_words w_sum;
    salsa8_pkg::t_out   n_result;
    salsa8_pkg::t_out   r_result;
    logic               r_valid;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_sum[i] = i_words[i] + i_orig[i];
        end
        n_result.out_words_0_1   = {w_sum[1],  w_sum[0]};
        n_result.out_words_2_3   = {w_sum[3],  w_sum[2]};
        n_result.out_words_4_5   = {w_sum[5],  w_sum[4]};
        n_result.out_words_6_7   = {w_sum[7],  w_sum[6]};
        n_result.out_words_8_9   = {w_sum[9],  w_sum[8]};
        n_result.out_words_10_11 = {w_sum[11], w_sum[10]};
        n_result.out_words_12_13 = {w_sum[13], w_sum[12]};
        n_result.out_words_14_15 = {w_sum[15], w_sum[14]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ src/salsa20_8_core_permutation.sv @@
// ----------------------------------------------------------------------------
// Salsa20/8 core permutation
// Fully pipelined Salsa20 core: one quarter-round step per stage, four lanes
// per stage, then a merge stage that adds the input words back.
//
//   Channel   Signals                   Transaction
//   input     start, busy, i_data       start high while busy low
//   result    o_done, o_result          o_done high for one cycle
//
// A transaction enters every cycle; busy stays low.
// The pipeline holds one stage per step of the quarter round in each round,
// set by the add-rotate-xor chain, plus the merge stage.
// Synchronous active-low reset clears the valid chain; data is not reset.
// The receiver cannot stall; each result appears for exactly one cycle.
// ----------------------------------------------------------------------------
`include "salsa20_8_core_permutation_defines.svh"

module salsa20_8_core_permutation (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  salsa8_pkg::t_in  i_data,
    output logic             o_done,
    output salsa8_pkg::t_out o_result
);

    logic               s_valid [salsa8_pkg::STAGES + 1];
    salsa8_pkg::t_words s_words [salsa8_pkg::STAGES + 1];
    salsa8_pkg::t_words s_orig  [salsa8_pkg::STAGES + 1];
    salsa8_pkg::t_words w_in;

    assign busy = 1'b0;

    assign w_in = {i_data.in_words_14_15, i_data.in_words_12_13,
                   i_data.in_words_10_11, i_data.in_words_8_9,
                   i_data.in_words_6_7,   i_data.in_words_4_5,
                   i_data.in_words_2_3,   i_data.in_words_0_1};

    assign s_valid[0] = start && !busy;
    assign s_words[0] = w_in;
    assign s_orig[0]  = w_in;

    for (genvar k = 0; k < salsa8_pkg::STAGES; k++) begin : g_stage
        salsa8_pkg::t_stage_ctl w_ctl;

        assign w_ctl.row  = 1'((k / salsa8_pkg::NSTEPS) % 2);
        assign w_ctl.step = 2'(k % salsa8_pkg::NSTEPS);

        salsa8_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_valid (s_valid[k]),
            .i_words (s_words[k]),
            .i_orig  (s_orig[k]),
            .o_valid (s_valid[k + 1]),
            .o_words (s_words[k + 1]),
            .o_orig  (s_orig[k + 1])
        );
    end

    salsa8_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid[salsa8_pkg::STAGES]),
        .i_words  (s_words[salsa8_pkg::STAGES]),
        .i_orig   (s_orig[salsa8_pkg::STAGES]),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    `SALSA8_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, start && !busy, s_valid[1])
    `SALSA8_ASSERT_NEXT(a_last_to_done, i_clk, i_rst_n, s_valid[salsa8_pkg::STAGES], o_done)
    `SALSA8_ASSERT_SAME(a_done_has_src, i_clk, i_rst_n, o_done, $past(s_valid[salsa8_pkg::STAGES]))

endmodule

@@ dv/salsa20_8_core_permutation_test.sv @@
// ----------------------------------------------------------------------------
// Salsa20/8 core permutation testbench
// Drives 512-bit blocks through the pipelined core under varying start gaps
// and checks every result block, word pair by word pair, against an in-order
// scoreboard fed by a behavioral Salsa20 core model.
// ----------------------------------------------------------------------------
module salsa20_8_core_permutation_test;

    localparam int ROT_B      = 7;
    localparam int ROT_C      = 9;
    localparam int ROT_D      = 13;
    localparam int ROT_A      = 18;
    localparam int NUM_RANDOM = 1700;
    localparam int PHASE_LEN  = 150;

    typedef struct {
        salsa8_pkg::t_in blk;
        int unsigned     idle_pct;
    } t_pending;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    salsa8_pkg::t_in   i_data  = '0;
    logic              busy;
    logic              o_done;
    salsa8_pkg::t_out  o_result;

    t_pending          block_q[$];
    salsa8_pkg::t_out  mixed_q[$];
    int                mismatches = 0;

    salsa20_8_core_permutation u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] rotl32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic salsa8_pkg::t_out salsa8_mix(salsa8_pkg::t_in blk);
        logic [31:0] orig [16];
        logic [31:0] w    [16];
        int unsigned ix   [4];
        logic [511:0] flat;
        logic [511:0] res;
        flat = blk;
        for (int i = 0; i < 16; i++) begin
            orig[i] = flat[32*i +: 32];
            w[i]    = orig[i];
        end
        for (int r = 0; r < salsa8_pkg::ROUNDS; r++) begin
            for (int l = 0; l < 4; l++) begin
                for (int k = 0; k < 4; k++) begin
                    if (r % 2 == 1) begin
                        ix[k] = 4 * l + (l + k) % 4;
                    end else begin
                        ix[k] = (5 * l + 4 * k) % 16;
                    end
                end
                w[ix[1]] ^= rotl32(32'(w[ix[0]] + w[ix[3]]), ROT_B);
                w[ix[2]] ^= rotl32(32'(w[ix[1]] + w[ix[0]]), ROT_C);
                w[ix[3]] ^= rotl32(32'(w[ix[2]] + w[ix[1]]), ROT_D);
                w[ix[0]] ^= rotl32(32'(w[ix[3]] + w[ix[2]]), ROT_A);
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[32*i +: 32] = 32'(w[i] + orig[i]);
        end
        return salsa8_pkg::t_out'(res);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR: %s", msg);
    endtask

    task automatic add_block(input logic [511:0] flat, input int unsigned pct);
        t_pending p;
        p.blk      = salsa8_pkg::t_in'(flat);
        p.idle_pct = pct;
        block_q.push_back(p);
    endtask

    function automatic logic [31:0] rand_word(int unsigned shape);
        logic [31:0] v;
        case (shape)
            0: v = $urandom;
            1: v = $urandom & $urandom & $urandom;
            2: v = $urandom | $urandom | $urandom;
            default: begin
                case ($urandom_range(4))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h8000_0000;
                    3: v = 32'h0000_0001;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic int unsigned phase_idle(int n);
        case ((n / PHASE_LEN) % 4)
            1: return 47;
            3: return 37;
            default: return 0;
        endcase
    endfunction

    // Driver: hold a transaction while busy, otherwise launch the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                mixed_q.push_back(salsa8_mix(i_data));
                void'(block_q.pop_front());
            end
            if (!(start && busy)) begin
                if (block_q.size() != 0 && $urandom_range(99) >= block_q[0].idle_pct) begin
                    start  <= 1'b1;
                    i_data <= block_q[0].blk;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: match each result transaction against the oldest expectation.
    always @(posedge i_clk) begin : mon
        salsa8_pkg::t_out want;
        if (i_rst_n && o_done) begin
            if (mixed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_result));
            end else begin
                want = mixed_q.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (o_result[64*k +: 64] !== want[64*k +: 64]) begin
                        report_mismatch($sformatf("words %0d/%0d: got %h want %h",
                            2 * k, 2 * k + 1, o_result[64*k +: 64], want[64*k +: 64]));
                    end
                end
            end
        end
    end

    initial begin
        logic [511:0] flat;
        int unsigned  shape;

        add_block('0, 0);
        add_block('1, 0);
        add_block({16{32'h8000_0000}}, 0);
        add_block({16{32'h0000_0001}}, 0);
        add_block({16{32'hAAAA_AAAA}}, 0);
        add_block({16{32'h5555_5555}}, 0);
        add_block({16{32'h7FFF_FFFF}}, 0);
        for (int i = 0; i < 16; i++) begin
            flat[32*i +: 32] = i;
        end
        add_block(flat, 0);
        add_block({32'hFFFF_FFFF, 480'h0}, 0);
        add_block({480'h0, 32'hFFFF_FFFF}, 0);
        add_block({448'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 0);
        add_block({64'hFFFF_FFFF_FFFF_FFFF, 448'h0}, 0);
        add_block({8{64'hFFFF_FFFF_0000_0000}}, 0);
        add_block({8{64'h0000_0000_FFFF_FFFF}}, 0);
        add_block({1'b1, 511'h0}, 0);
        add_block({511'h0, 1'b1}, 0);
        for (int i = 0; i < 4; i++) begin
            add_block({16{$urandom}}, 47);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            shape = $urandom_range(3);
            for (int i = 0; i < 16; i++) begin
                flat[32*i +: 32] = rand_word(shape);
            end
            add_block(flat, phase_idle(n));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (block_q.size() != 0) @(posedge i_clk);
        while (mixed_q.size() != 0) @(posedge i_clk);
        repeat (2 * salsa8_pkg::LATENCY) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
